>>> rtl/kdts_pkg.sv
// ----------------------------------------------------------------------------
// kdts_pkg - shared constants and types
// Table sizing, field widths and the command/status bundles between the
// controller and the datapath of the keyed dedup table.
// ----------------------------------------------------------------------------
package kdts_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int KEY_BITS       = 64;
  localparam int MEAN_FRAC_BITS = 8;

  localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_BITS  = 31;
  localparam int SUM_BITS  = VAL_BITS + CNT_BITS;
  localparam int DVD_BITS  = SUM_BITS + MEAN_FRAC_BITS;
  localparam int MEAN_BITS = 39;
  localparam int OCNT_BITS = 7;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the incoming beat, restart the scan
    logic scan;       // walk the table one entry a cycle
    logic lookup;     // compare scanned keys against the held key
    logic update;     // write back hit or append, restart the scan
    logic acc;        // fold scanned values into sum/min/max
    logic div_start;  // launch the mean division
    logic clear;      // drop the table contents and the overflow flag
  } kdts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_keep;    // incoming price is strictly positive
    logic in_last;    // incoming beat closes the set
    logic last;       // held beat closes the set
    logic scan_done;  // every entry read and consumed
    logic hit_now;    // scanned key matches the held key
    logic empty;      // table holds no entry
    logic div_done;   // quotient ready
  } kdts_sts_t;

endpackage

>>> rtl/kdts_div.sv
// ----------------------------------------------------------------------------
// kdts_div - restoring divider
// Unsigned dividend by a small divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kdts_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [kdts_pkg::DVD_BITS-1:0] dividend,
  input  logic [kdts_pkg::CNT_BITS-1:0] divisor,
  output logic                          done,
  output logic [kdts_pkg::DVD_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(kdts_pkg::DVD_BITS + 1);

  logic [STEP_BITS-1:0]          step_r, step_nxt;
  logic                          done_r, done_nxt;
  logic [kdts_pkg::CNT_BITS-1:0] rem_r, rem_nxt;
  logic [kdts_pkg::DVD_BITS-1:0] dq_r, dq_nxt;
  logic [kdts_pkg::CNT_BITS-1:0] dsr_r, dsr_nxt;
  logic [kdts_pkg::CNT_BITS:0]   trial;
  logic                          qbit;

  always_comb begin
    trial    = {rem_r, dq_r[kdts_pkg::DVD_BITS-1]};
    qbit     = (trial >= {1'b0, dsr_r});
    step_nxt = step_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      step_nxt = STEP_BITS'(kdts_pkg::DVD_BITS);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dsr_nxt  = divisor;
    end else if (step_r != '0) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt  = qbit ? kdts_pkg::CNT_BITS'(trial - {1'b0, dsr_r})
                      : trial[kdts_pkg::CNT_BITS-1:0];
      dq_nxt   = {dq_r[kdts_pkg::DVD_BITS-2:0], qbit};
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> rtl/kdts_datapath.sv
// ----------------------------------------------------------------------------
// kdts_datapath - table storage, scan pipeline and statistics
// Key and value memories, the entry walk, sum/min/max and the mean divider.
// ----------------------------------------------------------------------------
module kdts_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kdts_pkg::kdts_cmd_t             cmd,
  output kdts_pkg::kdts_sts_t             sts,
  input  logic [63:0]                     in_item_key,
  input  logic [31:0]                     in_item_price,
  input  logic                            in_last_item,
  output logic                            out_empty_set,
  output logic [kdts_pkg::OCNT_BITS-1:0]  out_distinct_count,
  output logic [kdts_pkg::VAL_BITS-1:0]   out_min_price,
  output logic [kdts_pkg::VAL_BITS-1:0]   out_max_price,
  output logic [kdts_pkg::MEAN_BITS-1:0]  out_mean_price_q8,
  output logic                            out_table_overflow
);

  localparam int IW = kdts_pkg::IDX_BITS;
  localparam int CW = kdts_pkg::CNT_BITS;
  localparam int KW = kdts_pkg::KEY_BITS;
  localparam int VW = kdts_pkg::VAL_BITS;

  logic [KW-1:0] key_mem [kdts_pkg::TABLE_DEPTH];
  logic [VW-1:0] val_mem [kdts_pkg::TABLE_DEPTH];

  // held beat
  logic [KW-1:0] key_r;
  logic [VW-1:0] price_r;
  logic          last_r;

  // table bookkeeping
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;

  // scan pipeline
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;
  logic          issue;

  // lookup result
  logic          hit_r, hit_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;

  // statistics
  logic [kdts_pkg::SUM_BITS-1:0] sum_r, sum_nxt;
  logic [VW-1:0]                 min_r, min_nxt;
  logic [VW-1:0]                 max_r, max_nxt;

  // memory write port
  logic          key_we, val_we;
  logic [IW-1:0] wr_addr;

  logic                          div_done;
  logic [kdts_pkg::DVD_BITS-1:0] quotient;

  assign issue = cmd.scan && (scan_idx_r < count_r);

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    pend_nxt     = issue;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    sum_nxt      = sum_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    key_we       = 1'b0;
    val_we       = 1'b0;
    wr_addr      = hit_r ? hit_idx_r : count_r[IW-1:0];

    if (issue) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
    end
    if (cmd.lookup && pend_r && (key_q == key_r)) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = pend_idx_r;
    end
    if (cmd.acc && pend_r) begin
      sum_nxt = sum_r + kdts_pkg::SUM_BITS'(val_q);
      if (val_q < min_r) min_nxt = val_q;
      if (val_q > max_r) max_nxt = val_q;
    end
    if (cmd.update) begin
      // overwrite on hit, append on miss, flag when full
      if (hit_r) begin
        val_we = 1'b1;
      end else if (count_r < CW'(kdts_pkg::TABLE_DEPTH)) begin
        key_we    = 1'b1;
        val_we    = 1'b1;
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.load || cmd.update) begin
      // restart the walk and the accumulators
      scan_idx_nxt = '0;
      pend_nxt     = 1'b0;
      hit_nxt      = 1'b0;
      sum_nxt      = '0;
      min_nxt      = '1;
      max_nxt      = '0;
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      scan_idx_r <= scan_idx_nxt;
      pend_r     <= pend_nxt;
      hit_r      <= hit_nxt;
    end
    hit_idx_r  <= hit_idx_nxt;
    pend_idx_r <= scan_idx_r[IW-1:0];
    sum_r      <= sum_nxt;
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    if (cmd.load) begin
      key_r   <= in_item_key[KW-1:0];
      price_r <= in_item_price[VW-1:0];
      last_r  <= in_last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_r;
    if (val_we) val_mem[wr_addr] <= price_r;
    key_q <= key_mem[scan_idx_r[IW-1:0]];
    val_q <= val_mem[scan_idx_r[IW-1:0]];
  end

  kdts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_r, {kdts_pkg::MEAN_FRAC_BITS{1'b0}}}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    sts.in_keep   = !in_item_price[31] && (in_item_price != '0);
    sts.in_last   = in_last_item;
    sts.last      = last_r;
    sts.scan_done = !pend_r && (scan_idx_r == count_r);
    sts.hit_now   = pend_r && (key_q == key_r);
    sts.empty     = (count_r == '0);
    sts.div_done  = div_done;
  end

  assign out_empty_set      = (count_r == '0);
  assign out_distinct_count = kdts_pkg::OCNT_BITS'(count_r);
  assign out_min_price      = out_empty_set ? '0 : min_r;
  assign out_max_price      = out_empty_set ? '0 : max_r;
  assign out_mean_price_q8  = out_empty_set ? '0 : quotient[kdts_pkg::MEAN_BITS-1:0];
  assign out_table_overflow = ovf_r;

endmodule

>>> rtl/kdts_ctrl.sv
// ----------------------------------------------------------------------------
// kdts_ctrl - sequencing state machine
// Steps each kept beat through lookup and write back, and a closing beat through statistics, divide and report.
// ----------------------------------------------------------------------------
module kdts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output kdts_pkg::kdts_cmd_t cmd,
  input  kdts_pkg::kdts_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_STATS,
    ST_DIVIDE,
    ST_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_keep)      state_nxt = ST_LOOKUP;
          else if (sts.in_last) state_nxt = ST_STATS;
        end
      end
      ST_LOOKUP: begin
        cmd.scan   = 1'b1;
        cmd.lookup = 1'b1;
        if (sts.hit_now || sts.scan_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? ST_STATS : ST_IDLE;
      end
      ST_STATS: begin
        cmd.scan = 1'b1;
        cmd.acc  = 1'b1;
        if (sts.scan_done) begin
          if (sts.empty) begin
            state_nxt = ST_REPORT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != ST_IDLE);
      out_valid_r <= (state_nxt == ST_REPORT);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/keyed_dedup_table_stats.sv
// ----------------------------------------------------------------------------
// keyed_dedup_table_stats - keyed dedup table with set summary
// Keeps the last positive price per distinct key and reports count, min,
// max and mean when a set closes.
// ----------------------------------------------------------------------------
// Drive start with a beat while busy is low; the beat is taken on that edge.
// Beats whose price is zero or negative are dropped (busy stays low unless
// the beat is marked last). A kept beat walks the key memory one entry per
// cycle through a registered read port, then a hit overwrites the stored
// price in place and a miss appends, or sets the overflow flag when the
// table is full. A beat marked last then walks the value memory for
// sum/min/max and runs a one-bit-per-cycle divider for the mean (skipped
// for an empty set) before the summary appears. The summary sits on the
// out_ ports for exactly one cycle with out_valid high; there is no way
// to hold it off, so capture it then. The table and the overflow flag are
// empty again once busy falls after the summary.
// ----------------------------------------------------------------------------
module keyed_dedup_table_stats (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [63:0]                    in_item_key,
  input  logic [31:0]                    in_item_price,
  input  logic                           in_last_item,
  output logic                           out_valid,
  output logic                           out_empty_set,
  output logic [kdts_pkg::OCNT_BITS-1:0] out_distinct_count,
  output logic [kdts_pkg::VAL_BITS-1:0]  out_min_price,
  output logic [kdts_pkg::VAL_BITS-1:0]  out_max_price,
  output logic [kdts_pkg::MEAN_BITS-1:0] out_mean_price_q8,
  output logic                           out_table_overflow
);

  kdts_pkg::kdts_cmd_t cmd;
  kdts_pkg::kdts_sts_t sts;

  // sequencing: accept beats, step the table walk, fire the summary
  kdts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage, scan and arithmetic
  kdts_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_item_key        (in_item_key),
    .in_item_price      (in_item_price),
    .in_last_item       (in_last_item),
    .out_empty_set      (out_empty_set),
    .out_distinct_count (out_distinct_count),
    .out_min_price      (out_min_price),
    .out_max_price      (out_max_price),
    .out_mean_price_q8  (out_mean_price_q8),
    .out_table_overflow (out_table_overflow)
  );

`ifndef SYNTH
  // summary is a single-cycle strobe
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("summary strobe held");

  // summary appears only while the block is working
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("summary while idle");

  // never more entries than the table holds
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distinct_count <= kdts_pkg::OCNT_BITS'(kdts_pkg::TABLE_DEPTH)))
    else $error("distinct count out of range");

  // non-empty set: min, mean and max stay ordered
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_set) |->
      ((out_min_price <= out_max_price) &&
       (out_mean_price_q8 >= {out_min_price, 8'h00}) &&
       (out_mean_price_q8 <= {out_max_price, 8'h00})))
    else $error("summary statistics out of order");

  // empty set reports zeros
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_set) |->
      ((out_distinct_count == '0) && (out_mean_price_q8 == '0)))
    else $error("empty summary not zero");
`endif

endmodule
